// ----- hdl/msr_intercept_table_unit_macros.svh -----
// Assertion macros used by the intercept table datapath.
// Each expects clk and rst in scope.
`ifndef MSR_INTERCEPT_TABLE_UNIT_MACROS_SVH
`define MSR_INTERCEPT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define MIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mit_pkg.sv -----
package mit_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    REQ_INSTALL = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_READ    = 2'd2,
    REQ_WRITE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_HANDLER = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/mit_req_if.sv -----
interface mit_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] msr_number;
  logic        want_read_hook;
  logic        want_write_hook;

  modport source (
    output valid, req_type, msr_number, want_read_hook, want_write_hook,
    input  ready
  );
  modport sink (
    input  valid, req_type, msr_number, want_read_hook, want_write_hook,
    output ready
  );
endinterface

// ----- hdl/mit_rsp_if.sv -----
interface mit_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       hit;
  logic       call_handler;
  logic [3:0] slot_index;

  modport source (
    output valid, status, hit, call_handler, slot_index,
    input  ready
  );
  modport sink (
    input  valid, status, hit, call_handler, slot_index,
    output ready
  );
endinterface

// ----- hdl/mit_ctrl.sv -----
module mit_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  mit_pkg::stat_t stat,
  output logic          req_ready,
  output mit_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Take an item only when the result register can absorb it.
  assign req_ready = (state == S_IDLE) && stat.out_free;
  assign cmd.load  = req_ready && req_valid;
  assign cmd.exec  = (state == S_EXEC);

  always_comb begin
    case (state)
      S_IDLE:  state_next = cmd.load ? S_EXEC : S_IDLE;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/mit_datapath.sv -----
`include "msr_intercept_table_unit_macros.svh"

module mit_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mit_pkg::cmd_t  cmd,
  output mit_pkg::stat_t stat,
  input  logic [1:0]     req_type,
  input  logic [31:0]    msr_number,
  input  logic           want_read_hook,
  input  logic           want_write_hook,
  mit_rsp_if.source      rsp
);

  localparam int N = mit_pkg::TABLE_ENTRIES;
  localparam int W = mit_pkg::IDX_W;

  // Latched request
  mit_pkg::req_t cur_type;
  logic [31:0]   cur_msr;
  logic          cur_rd;
  logic          cur_wr;

  // Table
  logic [N-1:0]  valid;
  logic [31:0]   regs [N];
  logic [N-1:0]  reads;
  logic [N-1:0]  writes;

  // Result register
  logic            rsp_valid;
  mit_pkg::status_t rsp_status;
  logic            rsp_hit;
  logic            rsp_call;
  logic [3:0]      rsp_slot;

  logic [N-1:0] match_vec;
  logic [N-1:0] match_low;
  logic [N-1:0] free_vec;
  logic [N-1:0] free_low;
  logic [W-1:0] match_idx;
  logic [W-1:0] free_idx;
  logic         any_match;
  logic         any_free;

  mit_pkg::status_t res_status;
  logic             res_hit;
  logic             res_call;
  logic [W-1:0]     res_slot;
  logic [W+3:0]     slot_wide;
  logic             wr_en;
  logic             clr_en;
  logic             hit_status_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_type <= mit_pkg::req_t'(req_type);
      cur_msr  <= msr_number;
      cur_rd   <= want_read_hook;
      cur_wr   <= want_write_hook;
    end
  end

  // Parallel compare, then isolate the lowest set bit.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i] = valid[i] && (regs[i] == cur_msr);
    end
    free_vec  = ~valid;
    match_low = match_vec & (~match_vec + 1'b1);
    free_low  = free_vec & (~free_vec + 1'b1);
    any_match = |match_vec;
    any_free  = |free_vec;
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < N; i++) begin
      if (match_low[i]) match_idx = match_idx | W'(i);
      if (free_low[i])  free_idx  = free_idx | W'(i);
    end
  end

  always_comb begin
    res_status = mit_pkg::ST_OK;
    res_hit    = 1'b0;
    res_call   = 1'b0;
    res_slot   = '0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    case (cur_type)
      mit_pkg::REQ_INSTALL: begin
        if (!cur_rd && !cur_wr) begin
          res_status = mit_pkg::ST_NO_HANDLER;
        end else if (any_match) begin
          res_status = mit_pkg::ST_DUPLICATE;
          res_hit    = 1'b1;
          res_slot   = match_idx;
        end else if (!any_free) begin
          res_status = mit_pkg::ST_FULL;
        end else begin
          res_slot = free_idx;
          wr_en    = 1'b1;
        end
      end
      mit_pkg::REQ_REMOVE, mit_pkg::REQ_READ, mit_pkg::REQ_WRITE: begin
        if (!any_match) begin
          res_status = mit_pkg::ST_NOT_FOUND;
        end else begin
          res_hit  = 1'b1;
          res_slot = match_idx;
          if (cur_type == mit_pkg::REQ_REMOVE) begin
            clr_en = 1'b1;
          end else if (cur_type == mit_pkg::REQ_READ) begin
            res_call = |(match_low & reads);
          end else begin
            res_call = |(match_low & writes);
          end
        end
      end
      default: begin
        res_status = mit_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Slot numbers beyond four bits keep only their low bits.
  assign slot_wide = {4'b0000, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.exec && wr_en) begin
      valid[free_idx] <= 1'b1;
    end else if (cmd.exec && clr_en) begin
      valid[match_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      regs[free_idx]   <= cur_msr;
      reads[free_idx]  <= cur_rd;
      writes[free_idx] <= cur_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_status <= res_status;
      rsp_hit    <= res_hit;
      rsp_call   <= res_call;
      rsp_slot   <= slot_wide[3:0];
    end
  end

  assign stat.out_free    = !rsp_valid || rsp.ready;
  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.hit          = rsp_hit;
  assign rsp.call_handler = rsp_call;
  assign rsp.slot_index   = rsp_slot;

  assign hit_status_ok = (rsp_status == mit_pkg::ST_OK) || (rsp_status == mit_pkg::ST_DUPLICATE);

  `MIT_ASSERT_NOW(a_exec_out_free, cmd.exec, !rsp_valid, "execute with result register full")
  `MIT_ASSERT_NEXT(a_install_marks, cmd.exec && wr_en, valid[$past(free_idx)], "install missed")
  `MIT_ASSERT_NEXT(a_remove_frees, cmd.exec && clr_en, !valid[$past(match_idx)], "remove missed")
  `MIT_ASSERT_NOW(a_hit_status, rsp_valid && rsp_hit, hit_status_ok, "hit with failing status")

endmodule

// ----- hdl/msr_intercept_table_unit.sv -----
// An accepted item is latched, and its result is registered on the output from
// the next edge; the result leaves when the receiver is ready.
// Items go through one at a time; an idle cycle takes the item and an
// execute cycle does the 16-way compare, free-slot pick and table write-back.
// A waiting result holds off the next item; an item may enter at the edge where
// the result leaves. Reset (synchronous, rst high): every slot freed at once,
// controller idle, result register empty; no clearing pass.
module msr_intercept_table_unit (
  input logic      clk,
  input logic      rst,
  mit_req_if.sink  req,
  mit_rsp_if.source rsp
);

  mit_pkg::cmd_t  cmd;
  mit_pkg::stat_t stat;
  logic           ready;

  // Sequencer: idle -> execute -> idle. It issues load and execute commands
  // and the request ready; all table and result state lives in the datapath.
  mit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .req_ready (ready),
    .cmd       (cmd)
  );

  // Table of entries, parallel match, lowest-free pick, result register.
  mit_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (req.req_type),
    .msr_number      (req.msr_number),
    .want_read_hook  (req.want_read_hook),
    .want_write_hook (req.want_write_hook),
    .rsp             (rsp)
  );

  // Hold off new items while one is executing or the result is stuck.
  assign req.ready = ready;

endmodule

// ----- verif/msr_intercept_table_unit_test.sv -----
module msr_intercept_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_PER_PHASE = 584;
  localparam int POOL_SIZE = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;

  // One lookup result as the block reports it.
  typedef struct packed {
    mit_pkg::status_t status;
    logic             hit;
    logic             call;
    logic [3:0]       slot;
  } lookup_result_t;

  // One row of the directed plan. A row with count above one repeats the
  // request with the register number stepped up by one each time. Rows with
  // use_fixed carry an expectation read straight off the spec; the rest are
  // left to the predictor.
  typedef struct packed {
    mit_pkg::req_t  kind;
    logic [31:0]    num;
    logic           rd;
    logic           wr;
    logic [7:0]     count;
    logic           use_fixed;
    lookup_result_t fixed;
  } directed_row_t;

  localparam lookup_result_t UNCHECKED = '0;
  localparam lookup_result_t MISS      = '{mit_pkg::ST_NOT_FOUND, 1'b0, 1'b0, 4'd0};
  localparam lookup_result_t NO_HOOK   = '{mit_pkg::ST_NO_HANDLER, 1'b0, 1'b0, 4'd0};

  localparam int PLAN_ROWS = 24;
  localparam directed_row_t PLAN [PLAN_ROWS] = '{
    // Empty table: every lookup, write and remove misses; an install with no hook is refused.
    '{mit_pkg::REQ_READ,    32'h0000_0000, 1'b0, 1'b0, 8'd1,  1'b1, MISS},
    '{mit_pkg::REQ_REMOVE,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'd1,  1'b1, MISS},
    '{mit_pkg::REQ_WRITE,   32'h1234_5678, 1'b0, 1'b0, 8'd1,  1'b1, MISS},
    '{mit_pkg::REQ_INSTALL, 32'h0000_0010, 1'b0, 1'b0, 8'd1,  1'b1, NO_HOOK},
    // Install at both ends of the number range, then a duplicate.
    '{mit_pkg::REQ_INSTALL, 32'h0000_0000, 1'b1, 1'b0, 8'd1,  1'b1,
      '{mit_pkg::ST_OK, 1'b0, 1'b0, 4'd0}},
    '{mit_pkg::REQ_INSTALL, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'd1,  1'b1,
      '{mit_pkg::ST_OK, 1'b0, 1'b0, 4'd1}},
    '{mit_pkg::REQ_INSTALL, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'd1,  1'b1,
      '{mit_pkg::ST_DUPLICATE, 1'b1, 1'b0, 4'd1}},
    // No handler wins over a duplicate number.
    '{mit_pkg::REQ_INSTALL, 32'h0000_0000, 1'b0, 1'b0, 8'd1,  1'b1, NO_HOOK},
    // Read and write lookups on both entries, each flag combination.
    '{mit_pkg::REQ_READ,    32'h0000_0000, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_WRITE,   32'h0000_0000, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_READ,    32'hFFFF_FFFF, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_WRITE,   32'hFFFF_FFFF, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    // Remove, then the write misses since nothing matches.
    '{mit_pkg::REQ_REMOVE,  32'h0000_0000, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_WRITE,   32'h0000_0000, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    // Freed slot zero is the lowest free one and gets reused.
    '{mit_pkg::REQ_INSTALL, 32'hAAAA_AAAA, 1'b1, 1'b1, 8'd1,  1'b0, UNCHECKED},
    // Fill the remaining fourteen slots.
    '{mit_pkg::REQ_INSTALL, 32'h5555_5554, 1'b1, 1'b0, 8'd14, 1'b0, UNCHECKED},
    '{mit_pkg::REQ_INSTALL, 32'h8000_0000, 1'b1, 1'b1, 8'd1,  1'b1,
      '{mit_pkg::ST_FULL, 1'b0, 1'b0, 4'd0}},
    // Duplicate is reported ahead of full.
    '{mit_pkg::REQ_INSTALL, 32'h5555_5557, 1'b1, 1'b1, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_READ,    32'h5555_5561, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_REMOVE,  32'h5555_5561, 1'b0, 1'b0, 8'd1,  1'b1,
      '{mit_pkg::ST_OK, 1'b1, 1'b0, 4'd15}},
    '{mit_pkg::REQ_REMOVE,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'd1,  1'b1,
      '{mit_pkg::ST_OK, 1'b1, 1'b0, 4'd1}},
    '{mit_pkg::REQ_INSTALL, 32'h8000_0000, 1'b0, 1'b1, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_REMOVE,  32'hAAAA_AAAA, 1'b0, 1'b0, 8'd1,  1'b0, UNCHECKED},
    '{mit_pkg::REQ_READ,    32'hAAAA_AAAA, 1'b0, 1'b0, 8'd1,  1'b1, MISS}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mit_req_if req_if ();
  mit_rsp_if rsp_if ();

  msr_intercept_table_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the intercept table.
  logic        slot_live   [mit_pkg::TABLE_ENTRIES];
  logic [31:0] slot_msr    [mit_pkg::TABLE_ENTRIES];
  logic        slot_reads  [mit_pkg::TABLE_ENTRIES];
  logic        slot_writes [mit_pkg::TABLE_ENTRIES];

  lookup_result_t pending_results [$];
  logic [31:0]    reg_pool [POOL_SIZE];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  // Apply one request to the shadow table and return the result it gives.
  function automatic lookup_result_t apply_request(mit_pkg::req_t kind,
                                                   logic [31:0] num,
                                                   logic rd, logic wr);
    lookup_result_t r;
    int found;
    int free_slot;
    int i;
    r = '0;
    r.status = mit_pkg::ST_OK;
    found = -1;
    free_slot = -1;
    // Scan downward so the lowest match and lowest free slot win.
    for (i = mit_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_msr[i] == num) found = i;
      if (!slot_live[i]) free_slot = i;
    end
    if (kind == mit_pkg::REQ_INSTALL) begin
      if (!rd && !wr) begin
        r.status = mit_pkg::ST_NO_HANDLER;
      end else if (found >= 0) begin
        r.status = mit_pkg::ST_DUPLICATE;
        r.hit = 1'b1;
        r.slot = 4'(found);
      end else if (free_slot < 0) begin
        r.status = mit_pkg::ST_FULL;
      end else begin
        slot_live[free_slot] = 1'b1;
        slot_msr[free_slot] = num;
        slot_reads[free_slot] = rd;
        slot_writes[free_slot] = wr;
        r.slot = 4'(free_slot);
      end
    end else if (found < 0) begin
      r.status = mit_pkg::ST_NOT_FOUND;
    end else begin
      r.hit = 1'b1;
      r.slot = 4'(found);
      case (kind)
        mit_pkg::REQ_REMOVE: slot_live[found] = 1'b0;
        mit_pkg::REQ_READ:   r.call = slot_reads[found];
        default:             r.call = slot_writes[found];
      endcase
    end
    return r;
  endfunction

  // Present one request, hold it until the block takes it, then record the
  // expected result. Valid is only dropped when an idle gap is chosen.
  task automatic send_item(input mit_pkg::req_t kind, input logic [31:0] num,
                           input logic rd, input logic wr, input logic use_fixed,
                           input lookup_result_t fixed);
    lookup_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.req_type        <= kind;
    req_if.msr_number      <= num;
    req_if.want_read_hook  <= rd;
    req_if.want_write_hook <= wr;
    do @(posedge clk); while (!req_if.ready);
    // The predictor always runs so the shadow table tracks the block.
    predicted = apply_request(kind, num, rd, wr);
    pending_results.push_back(use_fixed ? fixed : predicted);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Receiver: stall at the current rate, hold ready low through reset.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected: status %0d hit %0d call %0d slot %0d",
                 $time, rsp_if.status, rsp_if.hit, rsp_if.call_handler, rsp_if.slot_index);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report_field("status", int'(want.status), int'(rsp_if.status));
        report_field("hit", int'(want.hit), int'(rsp_if.hit));
        report_field("call_handler", int'(want.call), int'(rsp_if.call_handler));
        report_field("slot_index", int'(want.slot), int'(rsp_if.slot_index));
      end
    end
  end

  // Watchdog: give up after a long stretch with no item moving either way.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int row;
    int k;
    int phase;
    int n;
    int roll;
    logic filling;
    mit_pkg::req_t kind;
    logic [31:0] num;
    logic rd;
    logic wr;

    req_if.valid           = 1'b0;
    req_if.req_type        = mit_pkg::REQ_INSTALL;
    req_if.msr_number      = '0;
    req_if.want_read_hook  = 1'b0;
    req_if.want_write_hook = 1'b0;
    for (k = 0; k < mit_pkg::TABLE_ENTRIES; k++) slot_live[k] = 1'b0;

    // Keep the pool small against the table so installs collide and the
    // table fills; pin both ends of the number range into it.
    reg_pool[0] = 32'h0000_0000;
    reg_pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < POOL_SIZE; k++) reg_pool[k] = $urandom;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed plan, under the first idle pattern.
    send_idle_pct = 12;
    recv_stall_pct = 50;
    for (row = 0; row < PLAN_ROWS; row++) begin
      for (k = 0; k < int'(PLAN[row].count); k++) begin
        send_item(PLAN[row].kind, PLAN[row].num + 32'(k), PLAN[row].rd, PLAN[row].wr,
                  PLAN[row].use_fixed, PLAN[row].fixed);
      end
    end

    // Random part in three phases: sender-light idling, receiver-light
    // stalling, then full rate. Alternate between filling and draining the
    // table so full-table and not-found cases keep turning up.
    filling = 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_stall_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_stall_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 50 == 0) filling = !filling;
        rd = 1'($urandom_range(1));
        wr = 1'($urandom_range(1));
        if ($urandom_range(99) < 15) begin
          // Noise: any request on any number, mostly misses.
          kind = mit_pkg::req_t'($urandom_range(3));
          num = $urandom;
        end else begin
          num = reg_pool[$urandom_range(POOL_SIZE - 1)];
          roll = $urandom_range(99);
          if (filling) begin
            kind = (roll < 55) ? mit_pkg::REQ_INSTALL : (roll < 65) ? mit_pkg::REQ_REMOVE :
                   (roll < 83) ? mit_pkg::REQ_READ : mit_pkg::REQ_WRITE;
          end else begin
            kind = (roll < 15) ? mit_pkg::REQ_INSTALL : (roll < 60) ? mit_pkg::REQ_REMOVE :
                   (roll < 80) ? mit_pkg::REQ_READ : mit_pkg::REQ_WRITE;
          end
        end
        send_item(kind, num, rd, wr, 1'b0, UNCHECKED);
      end
      // Hold off the sender until every outstanding result is back.
      if (phase < 2) begin
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    // Drop valid, drain, and allow a few cycles for anything stray.
    @(posedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mit_pkg.sv
hdl/mit_req_if.sv
hdl/mit_rsp_if.sv
hdl/mit_ctrl.sv
hdl/mit_datapath.sv
hdl/msr_intercept_table_unit.sv
verif/msr_intercept_table_unit_test.sv
